// File: design/gae_pkg.sv
// Shared types, constants and coding functions for the genotype allele encoder.
package gae_pkg;

  localparam int LOCUS_W = 10;
  localparam int ALLELE_W = 8;
  localparam int CODE_W = 2;
  localparam int DEFAULT_NUM_LOCI = 1024;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam logic [ALLELE_W-1:0] CHAR_0 = 8'h30;
  localparam logic [ALLELE_W-1:0] CHAR_2 = 8'h32;
  localparam logic [ALLELE_W-1:0] CHAR_A = 8'h41;
  localparam logic [ALLELE_W-1:0] CHAR_C = 8'h43;
  localparam logic [ALLELE_W-1:0] CHAR_G = 8'h47;
  localparam logic [ALLELE_W-1:0] CHAR_T = 8'h54;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_NUMERIC   = 2'd1,
    MODE_LETTER    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    NUC_NONE = 3'd0,
    NUC_A    = 3'd1,
    NUC_C    = 3'd2,
    NUC_G    = 3'd3,
    NUC_T    = 3'd4
  } nuc_t;

  typedef struct packed {
    logic              digit;
    logic [CODE_W-1:0] dval;
    nuc_t              nuc;
  } allele_class_t;

  typedef struct packed {
    logic [LOCUS_W-1:0] locus;
    logic               in_range;
    allele_class_t      a1;
    allele_class_t      a2;
  } item_t;

  typedef struct packed {
    mode_t mode;
    nuc_t  first;
    nuc_t  second;
  } rec_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bad;
    rec_t              rec;
  } code_res_t;

  function automatic allele_class_t classify(logic [ALLELE_W-1:0] c);
    allele_class_t a;
    a.digit = (c >= CHAR_0) && (c <= CHAR_2);
    a.dval  = CODE_W'(c - CHAR_0);
    unique case (c)
      CHAR_A:  a.nuc = NUC_A;
      CHAR_C:  a.nuc = NUC_C;
      CHAR_G:  a.nuc = NUC_G;
      CHAR_T:  a.nuc = NUC_T;
      default: a.nuc = NUC_NONE;
    endcase
    return a;
  endfunction

  function automatic code_res_t code_allele(rec_t rec, allele_class_t a);
    code_res_t r;
    mode_t     m;
    r.code = '0;
    r.bad  = 1'b0;
    r.rec  = rec;
    m      = rec.mode;
    if (m == MODE_UNDECIDED) begin
      m = a.digit ? MODE_NUMERIC : MODE_LETTER;
    end
    r.rec.mode = m;
    case (m)
      MODE_NUMERIC: begin
        if (a.digit) begin
          r.code = a.dval;
        end else begin
          r.bad = 1'b1;
        end
      end
      MODE_LETTER: begin
        if (a.nuc == NUC_NONE) begin
          r.code = 2'd0;
        end else if (rec.first == NUC_NONE) begin
          r.rec.first = a.nuc;
          r.code      = 2'd1;
        end else if (a.nuc == rec.first) begin
          r.code = 2'd1;
        end else if (rec.second == NUC_NONE) begin
          r.rec.second = a.nuc;
          r.code       = 2'd2;
        end else if (a.nuc == rec.second) begin
          r.code = 2'd2;
        end else begin
          r.bad = 1'b1;
        end
      end
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: design/gae_front.sv
// Input side: accepts genotype words, checks the locus range and classifies both alleles.
module gae_front import gae_pkg::*; #(
  parameter int NUM_LOCI = DEFAULT_NUM_LOCI
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LOCUS_W-1:0]  in_locus,
  input  logic [ALLELE_W-1:0] in_first_allele,
  input  logic [ALLELE_W-1:0] in_second_allele,
  input  logic                clearing,
  input  logic                q_full,
  output logic                push,
  output item_t               push_item
);

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.locus    = in_locus;
    push_item.in_range = (int'(in_locus) < NUM_LOCI);
    push_item.a1       = classify(in_first_allele);
    push_item.a2       = classify(in_second_allele);
  end

endmodule

// File: design/gae_queue.sv
// Short queue of classified words between the input side and the table side.
module gae_queue import gae_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  item_t              push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output item_t              head_item,
  output logic [Q_CNT_W-1:0] count
);

  item_t               slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = Q_CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = Q_CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/gae_back.sv
// Table side: per-locus coding records, read-modify-write with forwarding, result register.
module gae_back import gae_pkg::*; #(
  parameter int NUM_LOCI = DEFAULT_NUM_LOCI
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  item_t             head_item,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_first_code,
  output logic              out_first_bad,
  output logic [CODE_W-1:0] out_second_code,
  output logic              out_second_bad,
  output logic              out_pair_error
);

  localparam int AW = (NUM_LOCI > 1) ? $clog2(NUM_LOCI) : 1;

  rec_t              table_mem [NUM_LOCI];
  rec_t              rd_rec_r;

  logic              clearing_r, clearing_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              s1_adv;

  logic              fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0]     fwd_addr_r;
  rec_t              fwd_rec_r;

  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] first_code_r, second_code_r;
  logic              first_bad_r, second_bad_r, pair_error_r;

  logic [AW-1:0]     head_addr, s1_addr, mem_waddr;
  logic              mem_we, stage_we;
  rec_t              mem_wdata, cur_rec;
  code_res_t         r1, r2;

  assign head_addr = AW'(head_item.locus);
  assign s1_addr   = AW'(s1_item_r.locus);
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign pop       = head_valid && !clearing_r && (!s1_valid_r || s1_adv);
  assign stage_we  = s1_adv && s1_item_r.in_range;
  assign clearing  = clearing_r;

  always_comb begin
    cur_rec = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_rec_r : rd_rec_r;
    r1      = code_allele(cur_rec, s1_item_r.a1);
    r2      = code_allele(r1.rec, s1_item_r.a2);
  end

  always_comb begin
    mem_we    = clearing_r || stage_we;
    mem_waddr = clearing_r ? clr_addr_r : s1_addr;
    mem_wdata = clearing_r ? rec_t'('0) : r2.rec;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_rec_r <= table_mem[head_addr];
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = AW'(clr_addr_r + 1'b1);
      if (clr_addr_r == AW'(NUM_LOCI - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    s1_valid_nxt  = pop || (s1_valid_r && !s1_adv);
    fwd_valid_nxt = fwd_valid_r || stage_we;
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= head_item;
    end
    if (stage_we) begin
      fwd_addr_r <= s1_addr;
      fwd_rec_r  <= r2.rec;
    end
    if (s1_adv) begin
      if (s1_item_r.in_range) begin
        first_code_r  <= r1.code;
        first_bad_r   <= r1.bad;
        second_code_r <= r2.code;
        second_bad_r  <= r2.bad;
        pair_error_r  <= r1.bad || r2.bad || ((r1.code != '0) != (r2.code != '0));
      end else begin
        first_code_r  <= '0;
        first_bad_r   <= 1'b1;
        second_code_r <= '0;
        second_bad_r  <= 1'b1;
        pair_error_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_code  = first_code_r;
  assign out_first_bad   = first_bad_r;
  assign out_second_code = second_code_r;
  assign out_second_bad  = second_bad_r;
  assign out_pair_error  = pair_error_r;

endmodule

// File: design/genotype_allele_encoder_unit.sv
// Top level of the genotype allele encoder: input side, queue and table side.
//
//   Channel  Handshake             Word
//   in_      in_valid / in_ready   in_locus, in_first_allele, in_second_allele
//   out_     out_valid / out_ready out_first_code, out_first_bad, out_second_code,
//                                  out_second_bad, out_pair_error
//
// One word per cycle is sustained while out_ready is high.
// The per-locus table has one read and one write port, and a one-entry write forward
// lets a word follow another at the same locus in the next cycle.
// After reset all NUM_LOCI table entries are cleared, during which in_ready is low.
// A stalled output fills the result register, the table stage and then the queue.
module genotype_allele_encoder_unit import gae_pkg::*; #(
  parameter int NUM_LOCI = DEFAULT_NUM_LOCI
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LOCUS_W-1:0]  in_locus,
  input  logic [ALLELE_W-1:0] in_first_allele,
  input  logic [ALLELE_W-1:0] in_second_allele,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CODE_W-1:0]   out_first_code,
  output logic                out_first_bad,
  output logic [CODE_W-1:0]   out_second_code,
  output logic                out_second_bad,
  output logic                out_pair_error
);

  logic               push, pop, q_full, head_valid, clearing;
  item_t              push_item, head_item;
  logic [Q_CNT_W-1:0] q_count;

  gae_front #(.NUM_LOCI(NUM_LOCI)) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_locus         (in_locus),
    .in_first_allele  (in_first_allele),
    .in_second_allele (in_second_allele),
    .clearing         (clearing),
    .q_full           (q_full),
    .push             (push),
    .push_item        (push_item)
  );

  gae_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  gae_back #(.NUM_LOCI(NUM_LOCI)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_first_code  (out_first_code),
    .out_first_bad   (out_first_bad),
    .out_second_code (out_second_code),
    .out_second_bad  (out_second_bad),
    .out_pair_error  (out_pair_error)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("Input accepted during table clear.");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_bad_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_first_bad || out_second_bad) |-> out_pair_error)
    else $error("Bad allele without pair error.");

  a_bad_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_bad |-> (out_first_code == '0))
    else $error("Bad first allele carries a nonzero code.");
`endif

endmodule
